### src/bdl_pkg.sv
// Package with the shared types and codes of the bounded doubly linked deque.
`timescale 1ns / 1ps

package bdl_pkg;

   localparam logic [3:0] OP_PUSH_FRONT = 4'd0;
   localparam logic [3:0] OP_PUSH_BACK  = 4'd1;
   localparam logic [3:0] OP_POP_FRONT  = 4'd2;
   localparam logic [3:0] OP_POP_BACK   = 4'd3;
   localparam logic [3:0] OP_REMOVE     = 4'd4;
   localparam logic [3:0] OP_FIND       = 4'd5;
   localparam logic [3:0] OP_READ       = 4'd6;
   localparam logic [3:0] OP_WRITE      = 4'd7;
   localparam logic [3:0] OP_CLEAR      = 4'd8;

   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_FULL     = 3'd1;
   localparam logic [2:0] ST_EMPTY    = 3'd2;
   localparam logic [2:0] ST_RANGE    = 3'd3;
   localparam logic [2:0] ST_NOTFOUND = 3'd4;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DISPATCH,
      S_WNODE,
      S_LINK,
      S_UNLINK,
      S_WALK
   } state_type;

   typedef enum logic [1:0] {
      RD_HEAD,
      RD_TAIL,
      RD_NEXT
   } rd_sel_type;

   typedef struct packed {
      logic       latch;
      rd_sel_type rd_sel;
      logic       load_node;
      logic       alloc;
      logic       write_node;
      logic       link;
      logic       unlink;
      logic       write_val;
      logic       clear;
      logic       respond;
      logic [2:0] rsp_status;
      logic       rsp_read;
   } cmd_type;

   typedef struct packed {
      logic [3:0] op;
      logic       empty;
      logic       full;
      logic       pos_ok;
      logic       match;
      logic       last;
      logic       at_pos;
   } stat_type;

endpackage

### src/bdl_ram.sv
// Generic single write port RAM with one registered read port.
`timescale 1ns / 1ps

module bdl_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

### src/bdl_ctrl.sv
// Controller state machine that sequences each deque operation.
`timescale 1ns / 1ps

module bdl_ctrl import bdl_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     start,
   input  stat_type stat,
   output logic     busy,
   output cmd_type  cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) state_in = S_DISPATCH;
         end
         S_DISPATCH: begin
            state_in = S_IDLE;
            case (stat.op)
               OP_PUSH_FRONT, OP_PUSH_BACK: begin
                  if (!stat.full) state_in = S_WNODE;
               end
               OP_POP_FRONT, OP_POP_BACK: begin
                  if (!stat.empty) state_in = S_UNLINK;
               end
               OP_REMOVE, OP_FIND: begin
                  if (!stat.empty) state_in = S_WALK;
               end
               OP_READ, OP_WRITE: begin
                  if (stat.pos_ok) state_in = S_WALK;
               end
               default: state_in = S_IDLE;
            endcase
         end
         S_WNODE: begin
            state_in = stat.empty ? S_IDLE : S_LINK;
         end
         S_LINK:   state_in = S_IDLE;
         S_UNLINK: state_in = S_IDLE;
         S_WALK: begin
            if (stat.op == OP_REMOVE || stat.op == OP_FIND) begin
               if (stat.match || stat.last) state_in = S_IDLE;
            end else if (stat.at_pos) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      cmd.rd_sel = RD_HEAD;
      cmd.rsp_status = ST_OK;
      case (state_ff)
         S_IDLE: cmd.latch = start;
         S_DISPATCH: begin
            case (stat.op)
               OP_PUSH_FRONT, OP_PUSH_BACK: begin
                  if (stat.full) begin
                     cmd.respond = 1'b1;
                     cmd.rsp_status = ST_FULL;
                  end else begin
                     cmd.alloc = 1'b1;
                  end
               end
               OP_POP_FRONT, OP_POP_BACK: begin
                  if (stat.empty) begin
                     cmd.respond = 1'b1;
                     cmd.rsp_status = ST_EMPTY;
                  end else begin
                     cmd.load_node = 1'b1;
                     cmd.rd_sel = (stat.op == OP_POP_FRONT) ? RD_HEAD : RD_TAIL;
                  end
               end
               OP_REMOVE, OP_FIND: begin
                  if (stat.empty) begin
                     cmd.respond = 1'b1;
                     cmd.rsp_status = ST_NOTFOUND;
                  end else begin
                     cmd.load_node = 1'b1;
                  end
               end
               OP_READ, OP_WRITE: begin
                  if (!stat.pos_ok) begin
                     cmd.respond = 1'b1;
                     cmd.rsp_status = ST_RANGE;
                  end else begin
                     cmd.load_node = 1'b1;
                  end
               end
               OP_CLEAR: begin
                  cmd.clear = 1'b1;
                  cmd.respond = 1'b1;
               end
               default: cmd.respond = 1'b1;
            endcase
         end
         S_WNODE: begin
            cmd.write_node = 1'b1;
            cmd.respond = stat.empty;
         end
         S_LINK: begin
            cmd.link = 1'b1;
            cmd.respond = 1'b1;
         end
         S_UNLINK: begin
            cmd.unlink = 1'b1;
            cmd.respond = 1'b1;
         end
         S_WALK: begin
            if (stat.op == OP_REMOVE || stat.op == OP_FIND) begin
               if (stat.match) begin
                  cmd.unlink = (stat.op == OP_REMOVE);
                  cmd.respond = 1'b1;
               end else if (stat.last) begin
                  cmd.respond = 1'b1;
                  cmd.rsp_status = ST_NOTFOUND;
               end else begin
                  cmd.load_node = 1'b1;
                  cmd.rd_sel = RD_NEXT;
               end
            end else if (stat.at_pos) begin
               cmd.rsp_read = (stat.op == OP_READ);
               cmd.write_val = (stat.op == OP_WRITE);
               cmd.respond = 1'b1;
            end else begin
               cmd.load_node = 1'b1;
               cmd.rd_sel = RD_NEXT;
            end
         end
         default: cmd.respond = 1'b0;
      endcase
   end

endmodule

### src/bdl_datapath.sv
// Datapath with the node memories, free stack, list pointers and result registers.
`timescale 1ns / 1ps

module bdl_datapath import bdl_pkg::*; #(
   parameter int CAPACITY = 256
) (
   input  logic               clock,
   input  logic               reset,
   input  cmd_type            cmd,
   output stat_type           stat,
   input  logic [3:0]         req_opcode,
   input  logic signed [31:0] req_value,
   input  logic [7:0]         req_position,
   output logic               rsp_valid,
   output logic [2:0]         rsp_status,
   output logic signed [31:0] rsp_read_value,
   output logic [8:0]         rsp_entry_count
);

   localparam int IW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int CMPW = (CW > 8) ? CW : 8;
   localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

   logic [IW-1:0] head_ff, head_in, tail_ff, tail_in, node_ff, node_in, idx_ff, idx_in;
   logic [CW-1:0] count_ff, count_in, fresh_ff, fresh_in, ftop_ff, ftop_in, ftop_dec;
   logic [3:0]    op_ff, op_in;
   logic [31:0]   value_ff, value_in;
   logic [7:0]    pos_ff, pos_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [2:0]    status_ff, status_in;
   logic [31:0]   read_ff, read_in;
   logic [8:0]    rcount_ff, rcount_in;

   logic [31:0]   val_rd, val_wd;
   logic [IW-1:0] next_rd, prev_rd, free_rd, node_raddr;
   logic [IW-1:0] val_wa, next_wa, next_wd, prev_wa, prev_wd, free_wa;
   logic          val_we, next_we, prev_we, free_we;

   bdl_ram #(.WIDTH(32), .DEPTH(CAPACITY)) u_values (
      .clock(clock), .wr_en(val_we), .wr_addr(val_wa), .wr_data(val_wd),
      .rd_addr(node_raddr), .rd_data(val_rd)
   );
   bdl_ram #(.WIDTH(IW), .DEPTH(CAPACITY)) u_next (
      .clock(clock), .wr_en(next_we), .wr_addr(next_wa), .wr_data(next_wd),
      .rd_addr(node_raddr), .rd_data(next_rd)
   );
   bdl_ram #(.WIDTH(IW), .DEPTH(CAPACITY)) u_prev (
      .clock(clock), .wr_en(prev_we), .wr_addr(prev_wa), .wr_data(prev_wd),
      .rd_addr(node_raddr), .rd_data(prev_rd)
   );
   bdl_ram #(.WIDTH(IW), .DEPTH(CAPACITY)) u_free (
      .clock(clock), .wr_en(free_we), .wr_addr(free_wa), .wr_data(node_ff),
      .rd_addr(ftop_ff[IW-1:0]), .rd_data(free_rd)
   );

   always_comb begin
      case (cmd.rd_sel)
         RD_HEAD: node_raddr = head_ff;
         RD_TAIL: node_raddr = tail_ff;
         RD_NEXT: node_raddr = next_rd;
         default: node_raddr = head_ff;
      endcase
   end

   assign ftop_dec = ftop_ff - CW'(1);

   always_comb begin
      head_in = head_ff;
      tail_in = tail_ff;
      node_in = node_ff;
      idx_in = idx_ff;
      count_in = count_ff;
      fresh_in = fresh_ff;
      ftop_in = ftop_ff;
      op_in = op_ff;
      value_in = value_ff;
      pos_in = pos_ff;
      val_we = 1'b0;
      val_wa = node_ff;
      val_wd = value_ff;
      next_we = 1'b0;
      next_wa = node_ff;
      next_wd = '0;
      prev_we = 1'b0;
      prev_wa = node_ff;
      prev_wd = '0;
      free_we = 1'b0;
      free_wa = ftop_dec[IW-1:0];

      if (cmd.latch) begin
         op_in = req_opcode;
         value_in = req_value;
         pos_in = req_position;
      end
      if (cmd.load_node) begin
         node_in = node_raddr;
         idx_in = (cmd.rd_sel == RD_NEXT) ? idx_ff + IW'(1) : '0;
      end
      // Released nodes are reused before the untouched region grows.
      if (cmd.alloc) begin
         if (ftop_ff < CAP_C) begin
            node_in = free_rd;
            ftop_in = ftop_ff + CW'(1);
         end else begin
            node_in = fresh_ff[IW-1:0];
            fresh_in = fresh_ff + CW'(1);
         end
      end
      if (cmd.write_node) begin
         val_we = 1'b1;
         next_we = 1'b1;
         prev_we = 1'b1;
         next_wd = (op_ff == OP_PUSH_FRONT && count_ff != '0) ? head_ff : '0;
         prev_wd = (op_ff == OP_PUSH_BACK && count_ff != '0) ? tail_ff : '0;
         if (count_ff == '0) begin
            head_in = node_ff;
            tail_in = node_ff;
            count_in = count_ff + CW'(1);
         end
      end
      if (cmd.link) begin
         if (op_ff == OP_PUSH_FRONT) begin
            prev_we = 1'b1;
            prev_wa = head_ff;
            prev_wd = node_ff;
            head_in = node_ff;
         end else begin
            next_we = 1'b1;
            next_wa = tail_ff;
            next_wd = node_ff;
            tail_in = node_ff;
         end
         count_in = count_ff + CW'(1);
      end
      // The links of the node being removed arrive from the read of the previous cycle.
      if (cmd.unlink) begin
         if (count_ff <= CW'(1)) begin
            head_in = '0;
            tail_in = '0;
         end else if (node_ff == head_ff) begin
            head_in = next_rd;
         end else if (node_ff == tail_ff) begin
            tail_in = prev_rd;
         end else begin
            next_we = 1'b1;
            next_wa = prev_rd;
            next_wd = next_rd;
            prev_we = 1'b1;
            prev_wa = next_rd;
            prev_wd = prev_rd;
         end
         count_in = count_ff - CW'(1);
         if (ftop_ff != '0) begin
            ftop_in = ftop_dec;
            free_we = 1'b1;
         end
      end
      if (cmd.write_val) begin
         val_we = 1'b1;
      end
      if (cmd.clear) begin
         head_in = '0;
         tail_in = '0;
         count_in = '0;
         fresh_in = '0;
         ftop_in = CAP_C;
      end
   end

   always_comb begin
      rsp_valid_in = cmd.respond;
      status_in = status_ff;
      read_in = read_ff;
      rcount_in = rcount_ff;
      if (cmd.respond) begin
         status_in = cmd.rsp_status;
         read_in = cmd.rsp_read ? val_rd : '0;
         rcount_in = 9'(count_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         tail_ff <= '0;
         count_ff <= '0;
         fresh_ff <= '0;
         ftop_ff <= CAP_C;
         rsp_valid_ff <= 1'b0;
      end else begin
         head_ff <= head_in;
         tail_ff <= tail_in;
         count_ff <= count_in;
         fresh_ff <= fresh_in;
         ftop_ff <= ftop_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      node_ff <= node_in;
      idx_ff <= idx_in;
      op_ff <= op_in;
      value_ff <= value_in;
      pos_ff <= pos_in;
      status_ff <= status_in;
      read_ff <= read_in;
      rcount_ff <= rcount_in;
   end

   always_comb begin
      stat.op = op_ff;
      stat.empty = (count_ff == '0);
      stat.full = (count_ff >= CAP_C);
      stat.pos_ok = (CMPW'(pos_ff) < CMPW'(count_ff));
      stat.match = (val_rd == value_ff);
      stat.last = ((CW'(idx_ff) + CW'(1)) == count_ff);
      stat.at_pos = (CMPW'(idx_ff) == CMPW'(pos_ff));
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_status = status_ff;
   assign rsp_read_value = read_ff;
   assign rsp_entry_count = rcount_ff;

endmodule

### src/bounded_doubly_linked_deque.sv
// Top level of the bounded doubly linked deque.
//
//   Channel   Handshake             Fields
//   request   start & !busy         req_opcode, req_value, req_position
//   response  rsp_valid (strobe)    rsp_status, rsp_read_value, rsp_entry_count
//
// One transaction at a time. Find, remove, read and write walk the next links one node per
// cycle, passing at most CAPACITY - 1 nodes. The response strobe comes in the cycle after
// the last step and the receiver cannot stall it; a new transaction may be accepted in the
// same cycle as the strobe. Synchronous reset empties the list, with no clearing pass.
`timescale 1ns / 1ps

module bounded_doubly_linked_deque import bdl_pkg::*; #(
   parameter int CAPACITY = 256
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [3:0]         req_opcode,
   input  logic signed [31:0] req_value,
   input  logic [7:0]         req_position,
   output logic               rsp_valid,
   output logic [2:0]         rsp_status,
   output logic signed [31:0] rsp_read_value,
   output logic [8:0]         rsp_entry_count
);

   cmd_type  cmd;
   stat_type stat;

   bdl_ctrl u_ctrl (
      .clock(clock), .reset(reset), .start(start), .stat(stat), .busy(busy), .cmd(cmd)
   );

   bdl_datapath #(.CAPACITY(CAPACITY)) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .stat(stat),
      .req_opcode(req_opcode), .req_value(req_value), .req_position(req_position),
      .rsp_valid(rsp_valid), .rsp_status(rsp_status), .rsp_read_value(rsp_read_value),
      .rsp_entry_count(rsp_entry_count)
   );

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted transaction did not make the block busy");

   a_rsp_after_work: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("response without a transaction in progress");

   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_FULL |-> rsp_entry_count == 9'(CAPACITY))
      else $error("full reported while the list is not full");

   a_empty_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_EMPTY |-> rsp_entry_count == 9'd0)
      else $error("empty reported while the list holds entries");

endmodule
